>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros used by the top-level rtl file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold on every clock edge out of reset
`define HVD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// condition must never be seen out of reset
`define HVD_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

>>> hw/rtl/hvd_pkg.sv
// ----------------------------------------------------------------------------
// hvd_pkg
// types, constants and tables of the haversine distance pipeline
// ----------------------------------------------------------------------------
package hvd_pkg;

    localparam int CORDIC_ITERATIONS = 24;

    localparam int ANG_W   = 27;
    localparam int CW      = 34;
    localparam int RAD_W   = 61;
    localparam int ROOT_W  = 31;
    localparam int ROOT_RW = 62;
    localparam int ROOT_STEPS = 31;
    localparam int H_W     = 31;
    localparam int DIST_W  = 26;

    typedef logic signed [ANG_W-1:0] angle_t;
    typedef logic signed [CW-1:0]    cdata_t;

    localparam angle_t TURN_Q17    = 27'sd47185920;
    localparam angle_t HALF_Q17    = 27'sd23592960;
    localparam angle_t QUARTER_Q17 = 27'sd11796480;

    localparam cdata_t GAIN_Q30 = 34'sd652032874;
    localparam logic signed [31:0] RAD_PER_DEG_Q36 = 32'sd1199381129;
    localparam logic [H_W-1:0] ONE_Q30 = 31'd1073741824;
    localparam logic [DIST_W-1:0] DIST_MAX = 26'd52707179;

    localparam logic [1:0] CFG_REF_LAT = 2'd0;
    localparam logic [1:0] CFG_REF_LON = 2'd1;
    localparam logic [1:0] CFG_RADIUS  = 2'd2;

    function automatic cdata_t atan_q30(input int i);
        cdata_t a;
        case (i)
            0: a = 34'sd843314857;
            1: a = 34'sd497837829;
            2: a = 34'sd263043837;
            3: a = 34'sd133525159;
            4: a = 34'sd67021687;
            5: a = 34'sd33543516;
            6: a = 34'sd16775851;
            7: a = 34'sd8388437;
            8: a = 34'sd4194283;
            9: a = 34'sd2097149;
            default:
            begin
                if (i <= 30)
                    a = cdata_t'(1) << (30 - i);
                else
                    a = '0;
            end
        endcase
        return a;
    endfunction

endpackage

>>> hw/rtl/hvd_sincos.sv
// ----------------------------------------------------------------------------
// hvd_sincos
// angle reduction and rotation cordic, sine and cosine in q30 of a q17 angle
// ----------------------------------------------------------------------------
module hvd_sincos (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           in_valid,
    input  hvd_pkg::angle_t angle,
    output logic           out_valid,
    output hvd_pkg::cdata_t sin_val,
    output hvd_pkg::cdata_t cos_val
);
    import hvd_pkg::*;

    localparam int N = CORDIC_ITERATIONS;

    angle_t wrap;
    angle_t fold_next;
    logic   flip_next;

    logic signed [24:0] fold_reg;
    logic               flip0_reg;
    logic               vld0_reg;
    logic signed [56:0] zprod;

    cdata_t x_reg [0:N];
    cdata_t y_reg [0:N];
    cdata_t z_reg [0:N];
    logic   flip_reg [0:N];
    logic   vld_reg [0:N];

    always_comb
    begin
        if (angle > HALF_Q17)
            wrap = angle - TURN_Q17;
        else if (angle <= -HALF_Q17)
            wrap = angle + TURN_Q17;
        else
            wrap = angle;
        fold_next = wrap;
        flip_next = 1'b0;
        if (wrap > QUARTER_Q17)
        begin
            fold_next = HALF_Q17 - wrap;
            flip_next = 1'b1;
        end
        else if (wrap < -QUARTER_Q17)
        begin
            fold_next = -HALF_Q17 - wrap;
            flip_next = 1'b1;
        end
    end

    assign zprod = 57'(fold_reg * RAD_PER_DEG_Q36) + 57'sd4194304;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld0_reg   <= 1'b0;
            vld_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            vld0_reg   <= in_valid;
            vld_reg[0] <= vld0_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fold_reg    <= fold_next[24:0];
            flip0_reg   <= flip_next;
            x_reg[0]    <= GAIN_Q30;
            y_reg[0]    <= '0;
            z_reg[0]    <= cdata_t'(zprod >>> 23);
            flip_reg[0] <= flip0_reg;
        end
    end

    for (genvar i = 0; i < N; i++)
    begin : g_rot
        cdata_t dx;
        cdata_t dy;
        cdata_t x_next;
        cdata_t y_next;
        cdata_t z_next;

        always_comb
        begin
            dx = y_reg[i] >>> i;
            dy = x_reg[i] >>> i;
            if (z_reg[i] >= 0)
            begin
                x_next = x_reg[i] - dx;
                y_next = y_reg[i] + dy;
                z_next = z_reg[i] - atan_q30(i);
            end
            else
            begin
                x_next = x_reg[i] + dx;
                y_next = y_reg[i] - dy;
                z_next = z_reg[i] + atan_q30(i);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[i+1] <= 1'b0;
            else if (en)
                vld_reg[i+1] <= vld_reg[i];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[i+1]    <= x_next;
                y_reg[i+1]    <= y_next;
                z_reg[i+1]    <= z_next;
                flip_reg[i+1] <= flip_reg[i];
            end
        end
    end

    assign out_valid = vld_reg[N];
    assign sin_val   = y_reg[N];
    assign cos_val   = flip_reg[N] ? -x_reg[N] : x_reg[N];

endmodule

>>> hw/rtl/hvd_hav.sv
// ----------------------------------------------------------------------------
// hvd_hav
// haversine term from the sines and cosines, clamped to [0, 1] in q30
// ----------------------------------------------------------------------------
module hvd_hav (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  hvd_pkg::cdata_t u,
    input  hvd_pkg::cdata_t v,
    input  hvd_pkg::cdata_t ca,
    input  hvd_pkg::cdata_t cb,
    output logic            out_valid,
    output logic [hvd_pkg::H_W-1:0] h
);
    import hvd_pkg::*;

    logic signed [67:0] uu_prod;
    logic signed [67:0] vv_prod;
    logic signed [67:0] cc_prod;
    logic signed [71:0] p_prod;
    logic signed [36:0] h_sum;

    logic signed [35:0] uu1_reg;
    logic signed [35:0] vv1_reg;
    logic signed [35:0] cc1_reg;
    logic signed [35:0] uu2_reg;
    logic signed [35:0] p2_reg;
    logic [H_W-1:0]     h_reg;
    logic               vld1_reg;
    logic               vld2_reg;
    logic               vld3_reg;

    assign uu_prod = u * u;
    assign vv_prod = v * v;
    assign cc_prod = ca * cb;
    assign p_prod  = cc1_reg * vv1_reg;
    assign h_sum   = 37'(uu2_reg) + 37'(p2_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
        end
        else if (en)
        begin
            vld1_reg <= in_valid;
            vld2_reg <= vld1_reg;
            vld3_reg <= vld2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            uu1_reg <= uu_prod[65:30];
            vv1_reg <= vv_prod[65:30];
            cc1_reg <= cc_prod[65:30];
            uu2_reg <= uu1_reg;
            p2_reg  <= p_prod[65:30];
            if (h_sum < 0)
                h_reg <= '0;
            else if (h_sum > 37'(ONE_Q30))
                h_reg <= ONE_Q30;
            else
                h_reg <= h_sum[H_W-1:0];
        end
    end

    assign out_valid = vld3_reg;
    assign h         = h_reg;

endmodule

>>> hw/rtl/hvd_isqrt.sv
// ----------------------------------------------------------------------------
// hvd_isqrt
// exact integer square root, one result bit per pipeline stage
// ----------------------------------------------------------------------------
module hvd_isqrt (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       in_valid,
    input  logic [hvd_pkg::RAD_W-1:0]  radicand,
    output logic                       out_valid,
    output logic [hvd_pkg::ROOT_W-1:0] root
);
    import hvd_pkg::*;

    logic [RAD_W-1:0]   rem_reg [0:ROOT_STEPS];
    logic [ROOT_RW-1:0] res_reg [0:ROOT_STEPS];
    logic               vld_reg [0:ROOT_STEPS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg[0] <= 1'b0;
        else if (en)
            vld_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= radicand;
            res_reg[0] <= '0;
        end
    end

    for (genvar s = 0; s < ROOT_STEPS; s++)
    begin : g_digit
        localparam logic [ROOT_RW-1:0] STEP_ONE =
            ROOT_RW'(1) << (2 * (ROOT_STEPS - 1 - s));

        logic [ROOT_RW-1:0] trial;
        logic               take;

        assign trial = res_reg[s] + STEP_ONE;
        assign take  = ROOT_RW'(rem_reg[s]) >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[s+1] <= 1'b0;
            else if (en)
                vld_reg[s+1] <= vld_reg[s];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (take)
                begin
                    rem_reg[s+1] <= rem_reg[s] - trial[RAD_W-1:0];
                    res_reg[s+1] <= (res_reg[s] >> 1) + STEP_ONE;
                end
                else
                begin
                    rem_reg[s+1] <= rem_reg[s];
                    res_reg[s+1] <= res_reg[s] >> 1;
                end
            end
        end
    end

    assign out_valid = vld_reg[ROOT_STEPS];
    assign root      = res_reg[ROOT_STEPS][ROOT_W-1:0];

endmodule

>>> hw/rtl/hvd_vec.sv
// ----------------------------------------------------------------------------
// hvd_vec
// vectoring cordic, angle of (x, y) in radians q30, clamped at zero
// ----------------------------------------------------------------------------
module hvd_vec (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       in_valid,
    input  logic [hvd_pkg::ROOT_W-1:0] x_in,
    input  logic [hvd_pkg::ROOT_W-1:0] y_in,
    output logic                       out_valid,
    output logic [hvd_pkg::ROOT_W-1:0] angle
);
    import hvd_pkg::*;

    localparam int N = CORDIC_ITERATIONS;

    cdata_t x_reg [0:N];
    cdata_t y_reg [0:N];
    cdata_t z_reg [0:N];
    logic   vld_reg [0:N];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg[0] <= 1'b0;
        else if (en)
            vld_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0] <= cdata_t'(x_in);
            y_reg[0] <= cdata_t'(y_in);
            z_reg[0] <= '0;
        end
    end

    for (genvar i = 0; i < N; i++)
    begin : g_vec
        cdata_t dx;
        cdata_t dy;
        cdata_t x_next;
        cdata_t y_next;
        cdata_t z_next;

        always_comb
        begin
            dx = y_reg[i] >>> i;
            dy = x_reg[i] >>> i;
            if (y_reg[i] >= 0)
            begin
                x_next = x_reg[i] + dx;
                y_next = y_reg[i] - dy;
                z_next = z_reg[i] + atan_q30(i);
            end
            else
            begin
                x_next = x_reg[i] - dx;
                y_next = y_reg[i] + dy;
                z_next = z_reg[i] - atan_q30(i);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[i+1] <= 1'b0;
            else if (en)
                vld_reg[i+1] <= vld_reg[i];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[i+1] <= x_next;
                y_reg[i+1] <= y_next;
                z_reg[i+1] <= z_next;
            end
        end
    end

    assign out_valid = vld_reg[N];
    assign angle     = (z_reg[N] < 0) ? '0 : z_reg[N][ROOT_W-1:0];

endmodule

>>> hw/rtl/haversine_distance_to_reference_top.sv
// ----------------------------------------------------------------------------
// haversine_distance_to_reference_top
// throughput: one word per cycle, the whole pipeline advances as one
// a held output word stalls every stage and the input
// reset: reference point and radius go to 55.7558, 37.6178 deg and 6371 km
// reset clears all valid bits, no clearing pass
// ----------------------------------------------------------------------------
module haversine_distance_to_reference_top (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic signed [23:0]          latitude,
    input  logic signed [24:0]          longitude,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [hvd_pkg::DIST_W-1:0]  distance,
    input  logic                        cfg_write,
    input  logic [1:0]                  cfg_index,
    input  logic [24:0]                 cfg_data
);
    import hvd_pkg::*;
    `include "assert_macros.svh"

    logic signed [23:0] ref_lat_reg;
    logic signed [24:0] ref_lon_reg;
    logic [23:0]        radius_reg;

    logic   en;
    angle_t a_dlat;
    angle_t a_dlon;
    angle_t a_lat;
    angle_t a_rlat;

    logic   sc_valid;
    cdata_t u;
    cdata_t v;
    cdata_t ca;
    cdata_t cb;

    logic             h_valid;
    logic [H_W-1:0]   h;
    logic [RAD_W-1:0] rad_a;
    logic [RAD_W-1:0] rad_b;

    logic              root_valid;
    logic [ROOT_W-1:0] sa;
    logic [ROOT_W-1:0] sb;

    logic              ang_valid;
    logic [ROOT_W-1:0] ang;

    logic [54:0]       prod_reg;
    logic              prod_vld_reg;
    logic [55:0]       d_round;
    logic [DIST_W-1:0] distance_reg;
    logic              out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_lat_reg <= 24'sd3654012;
            ref_lon_reg <= 25'sd2465320;
            radius_reg  <= 24'd1630976;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_REF_LAT: ref_lat_reg <= cfg_data[23:0];
                CFG_REF_LON: ref_lon_reg <= cfg_data;
                CFG_RADIUS:  radius_reg  <= cfg_data[23:0];
                default:     ;
            endcase
        end
    end

    assign en       = !out_valid_reg || !out_stall;
    assign in_stall = !en;

    assign a_dlat = angle_t'(ref_lat_reg) - angle_t'(latitude);
    assign a_dlon = angle_t'(ref_lon_reg) - angle_t'(longitude);
    assign a_lat  = angle_t'(latitude) <<< 1;
    assign a_rlat = angle_t'(ref_lat_reg) <<< 1;

    hvd_sincos u_sc_dlat (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .angle     (a_dlat),
        .out_valid (sc_valid),
        .sin_val   (u),
        .cos_val   ()
    );

    hvd_sincos u_sc_dlon (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .angle     (a_dlon),
        .out_valid (),
        .sin_val   (v),
        .cos_val   ()
    );

    hvd_sincos u_sc_lat (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .angle     (a_lat),
        .out_valid (),
        .sin_val   (),
        .cos_val   (ca)
    );

    hvd_sincos u_sc_rlat (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .angle     (a_rlat),
        .out_valid (),
        .sin_val   (),
        .cos_val   (cb)
    );

    hvd_hav u_hav (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sc_valid),
        .u         (u),
        .v         (v),
        .ca        (ca),
        .cb        (cb),
        .out_valid (h_valid),
        .h         (h)
    );

    assign rad_a = {h, 30'd0};
    assign rad_b = {ONE_Q30 - h, 30'd0};

    hvd_isqrt u_sqrt_h (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (h_valid),
        .radicand  (rad_a),
        .out_valid (root_valid),
        .root      (sa)
    );

    hvd_isqrt u_sqrt_c (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (h_valid),
        .radicand  (rad_b),
        .out_valid (),
        .root      (sb)
    );

    hvd_vec u_vec (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (root_valid),
        .x_in      (sb),
        .y_in      (sa),
        .out_valid (ang_valid),
        .angle     (ang)
    );

    // distance = round(2 * r * angle / 2^30)
    assign d_round = 56'(prod_reg) + 56'd268435456;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_vld_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            prod_vld_reg  <= ang_valid;
            out_valid_reg <= prod_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= 55'(radius_reg) * 55'(ang);
            if ((d_round >> 29) > 56'(DIST_MAX))
                distance_reg <= DIST_MAX;
            else
                distance_reg <= d_round[DIST_W+28:29];
        end
    end

    assign out_valid = out_valid_reg;
    assign distance  = distance_reg;

    `HVD_ASSERT(a_stall_only_when_full, in_stall |-> out_valid_reg, "stall without held word")
    `HVD_ASSERT(a_freeze_on_stall, !en |=> $stable(prod_vld_reg), "pipeline moved under stall")
    `HVD_NEVER(a_distance_range, out_valid_reg && (distance_reg > DIST_MAX), "distance over range")

endmodule

>>> tb/haversine_distance_to_reference_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// haversine_distance_to_reference_top_tb
// drives positions into the haversine distance pipeline under random input
// gaps and output stalls, predicts every distance word in fixed point and
// compares it in order; the reference point and radius are reprogrammed
// between phases, extremes included
// ----------------------------------------------------------------------------
module haversine_distance_to_reference_top_tb;

    import hvd_pkg::*;

    localparam int LAT_MAX    = 5898240;
    localparam int LON_MAX    = 11796480;
    localparam int RADIUS_MAX = 16777215;
    localparam int LATENCY    = 88;
    localparam longint CYCLE_LIMIT = 400000;
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic signed [23:0] latitude;
    logic signed [24:0] longitude;
    logic        out_valid;
    logic        out_stall;
    logic [DIST_W-1:0] distance;
    logic        cfg_write;
    logic [1:0]  cfg_index;
    logic [24:0] cfg_data;

    logic signed [23:0] ref_lat_q;
    logic signed [24:0] ref_lon_q;
    logic [23:0]        radius_q;

    logic [DIST_W-1:0] expected_distances[$];
    int     error_count;
    int     items_sent;
    int     words_checked;
    longint cycle_count;
    bit     gaps_on;
    bit     stalls_on;

    haversine_distance_to_reference_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .latitude  (latitude),
        .longitude (longitude),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .distance  (distance),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // arithmetic shift right with floor
    function automatic longint floor_shift(input longint v, input int s);
        return v >>> s;
    endfunction

    function automatic longint arctan_step(input int i);
        return longint'(atan_q30(i));
    endfunction

    // sine and cosine in q30 of an angle given in degrees q17
    task automatic rotate_angle(input longint a, output longint s, output longint c);
        longint r;
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        bit     flip;
        r = a % longint'(TURN_Q17);
        flip = 1'b0;
        x = longint'(GAIN_Q30);
        y = 0;
        if (r < 0)
            r += longint'(TURN_Q17);
        if (r > longint'(HALF_Q17))
            r -= longint'(TURN_Q17);
        if (r > longint'(QUARTER_Q17))
        begin
            r = longint'(HALF_Q17) - r;
            flip = 1'b1;
        end
        else if (r < -longint'(QUARTER_Q17))
        begin
            r = -longint'(HALF_Q17) - r;
            flip = 1'b1;
        end
        z = floor_shift(r * longint'(RAD_PER_DEG_Q36) + (64'sd1 <<< 22), 23);
        for (int i = 0; i < CORDIC_ITERATIONS; i++)
        begin
            dx = floor_shift(y, i);
            dy = floor_shift(x, i);
            if (z >= 0)
            begin
                x -= dx;
                y += dy;
                z -= arctan_step(i);
            end
            else
            begin
                x += dx;
                y -= dy;
                z += arctan_step(i);
            end
        end
        s = y;
        c = flip ? -x : x;
    endtask

    function automatic longint int_root(input longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end
            else
                res >>= 1;
            bitv >>= 2;
        end
        return longint'(res);
    endfunction

    function automatic longint arc_angle(input longint x, input longint y);
        longint z;
        longint dx;
        longint dy;
        z = 0;
        for (int i = 0; i < CORDIC_ITERATIONS; i++)
        begin
            dx = floor_shift(y, i);
            dy = floor_shift(x, i);
            if (y >= 0)
            begin
                x += dx;
                y -= dy;
                z += arctan_step(i);
            end
            else
            begin
                x -= dx;
                y += dy;
                z -= arctan_step(i);
            end
        end
        return z;
    endfunction

    task automatic predict_distance(input logic signed [23:0] lat,
                                    input logic signed [24:0] lon,
                                    output logic [DIST_W-1:0] d);
        longint u;
        longint v;
        longint ca;
        longint cb;
        longint unused;
        longint h;
        longint ang;
        longint sa;
        longint sb;
        longint unsigned prod;
        rotate_angle(longint'(ref_lat_q) - longint'(lat), u, unused);
        rotate_angle(longint'(ref_lon_q) - longint'(lon), v, unused);
        rotate_angle(longint'(lat) * 2, unused, ca);
        rotate_angle(longint'(ref_lat_q) * 2, unused, cb);
        h = floor_shift(u * u, 30)
            + floor_shift(floor_shift(ca * cb, 30) * floor_shift(v * v, 30), 30);
        if (h < 0)
            h = 0;
        if (h > longint'(ONE_Q30))
            h = longint'(ONE_Q30);
        sa = int_root(longint'(h) << 30);
        sb = int_root((longint'(ONE_Q30) - h) << 30);
        ang = arc_angle(sb, sa);
        if (ang < 0)
            ang = 0;
        prod = (64'd2 * longint'(radius_q) * longint'(ang) + (64'd1 << 29)) >> 30;
        if (prod > longint'(DIST_MAX))
            prod = longint'(DIST_MAX);
        d = prod[DIST_W-1:0];
    endtask

    // append a predicted word at the tail of the queue
    task automatic store_expected(input logic [DIST_W-1:0] d);
        expected_distances = {expected_distances, d};
    endtask

    // write enable stays high, the caller drops it after the last write
    task automatic write_register(input logic [1:0] index, input logic [24:0] value);
        cfg_write <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        case (index)
            CFG_REF_LAT: ref_lat_q = value[23:0];
            CFG_REF_LON: ref_lon_q = value[24:0];
            CFG_RADIUS:  radius_q  = value[23:0];
            default: ;
        endcase
    endtask

    task automatic load_reference(input int lat, input int lon, input int radius);
        write_register(CFG_REF_LAT, 25'(lat));
        write_register(CFG_REF_LON, 25'(lon));
        write_register(CFG_RADIUS, 25'(radius));
        cfg_write <= 1'b0;
    endtask

    task automatic drain_pipeline();
        while (expected_distances.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    // one position word, with a random gap ahead of it when gaps are on
    task automatic send_position(input logic signed [23:0] lat,
                                 input logic signed [24:0] lon);
        logic [DIST_W-1:0] d;
        while (gaps_on && $urandom_range(99) < 25)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        predict_distance(lat, lon, d);
        store_expected(d);
        in_valid  <= 1'b1;
        latitude  <= lat;
        longitude <= lon;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic idle_input();
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic signed [23:0] random_latitude();
        return 24'($signed($urandom_range(2 * LAT_MAX)) - LAT_MAX);
    endfunction

    function automatic logic signed [24:0] random_longitude();
        return 25'($signed($urandom_range(2 * LON_MAX)) - LON_MAX);
    endfunction

    task automatic test_field_extremes();
        send_position(24'sd0, 25'sd0);
        send_position(24'(LAT_MAX), 25'(LON_MAX));
        send_position(-24'(LAT_MAX), -25'(LON_MAX));
        send_position(24'(LAT_MAX), -25'(LON_MAX));
        send_position(-24'(LAT_MAX), 25'(LON_MAX));
        send_position(24'sd3654012, 25'sd2465320);
        send_position(-24'sd3654012, 25'sd2465320 - 25'(LON_MAX));
        send_position(24'sh7fffff, 25'sh0ffffff);
        send_position(24'sh800000, 25'sh1000000);
        send_position(24'shffffff, 25'sh1ffffff);
        idle_input();
    endtask

    // reference on the pole and out-of-range latitudes make the product negative
    task automatic test_beyond_pole();
        load_reference(LAT_MAX, 0, 1630976);
        send_position(24'sh7fffff, 25'sd0);
        send_position(24'sh800000, 25'(LON_MAX));
        send_position(-24'(LAT_MAX), 25'sd123456);
        send_position(24'sd1, 25'sd1);
        idle_input();
        drain_pipeline();
    endtask

    // largest radius saturates, zero radius gives zero
    task automatic test_radius_extremes();
        load_reference(-LAT_MAX, -LON_MAX, RADIUS_MAX);
        send_position(24'(LAT_MAX), 25'sd0);
        send_position(24'sd0, 25'sd0);
        send_position(-24'(LAT_MAX), -25'(LON_MAX));
        idle_input();
        drain_pipeline();
        load_reference(0, LON_MAX, 0);
        send_position(24'sd100000, 25'sd0);
        send_position(24'(LAT_MAX), 25'sd0);
        idle_input();
        drain_pipeline();
        write_register(CFG_UNUSED, 25'h1ffffff);
        load_reference(-24'sh800000, 25'h1000000, 1);
        send_position(24'sd0, 25'sd0);
        send_position(24'(LAT_MAX), 25'(LON_MAX));
        idle_input();
        drain_pipeline();
    endtask

    task automatic test_random_positions(input int count);
        for (int n = 0; n < count; n++)
        begin
            if (n % 200 == 0)
            begin
                idle_input();
                drain_pipeline();
                case ($urandom_range(3))
                    0: load_reference(3654012, 2465320, 1630976);
                    1: load_reference(int'(random_latitude()), int'(random_longitude()),
                                      int'($urandom_range(RADIUS_MAX)));
                    2: load_reference(int'(random_latitude()), int'(random_longitude()),
                                      int'($urandom_range(1630976)));
                    default: load_reference(int'(random_latitude()),
                                            int'(random_longitude()), RADIUS_MAX);
                endcase
                gaps_on   = (n != 600);
                stalls_on = (n != 600);
            end
            if ($urandom_range(19) == 0)
                send_position(24'($urandom), 25'($urandom));
            else
                send_position(random_latitude(), random_longitude());
        end
        idle_input();
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
            out_stall <= stalls_on && ($urandom_range(99) < 25);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_distances.size() == 0)
            begin
                $display("%0t: distance word %0d with none expected", $time, distance);
                error_count++;
            end
            else
            begin
                if (distance !== expected_distances[0])
                begin
                    $display("%0t: distance expected %0d actual %0d",
                             $time, expected_distances[0], distance);
                    error_count++;
                end
                void'(expected_distances.pop_front());
                words_checked++;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        latitude    = '0;
        longitude   = '0;
        out_stall   = 1'b0;
        cfg_write   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        error_count = 0;
        items_sent  = 0;
        words_checked = 0;
        cycle_count = 0;
        gaps_on     = 1'b1;
        stalls_on   = 1'b1;
        ref_lat_q   = 24'sd3654012;
        ref_lon_q   = 25'sd2465320;
        radius_q    = 24'd1630976;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_field_extremes();
        drain_pipeline();
        test_beyond_pole();
        test_radius_extremes();
        test_random_positions(1950);
        drain_pipeline();

        $display("sent %0d positions, checked %0d distances over several references",
                 items_sent, words_checked);
        if (error_count == 0 && expected_distances.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/hvd_pkg.sv
hw/rtl/hvd_sincos.sv
hw/rtl/hvd_hav.sv
hw/rtl/hvd_isqrt.sv
hw/rtl/hvd_vec.sv
hw/rtl/haversine_distance_to_reference_top.sv
tb/haversine_distance_to_reference_top_tb.sv
